/* rtl/wsfd_pkg.sv */
// Shared types and constants for the WebSocket frame deframer.
// No dependencies; imported by the deframer and its port checker.
`timescale 1ns / 1ps
`default_nettype none

package wsfd_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_CONNECTED = 2'd0;
  localparam logic [1:0] CFG_MAX_FRAME = 2'd1;

  localparam logic [31:0] MAX_FRAME_RESET = 32'd65536;

  // Error codes carried by a result item
  localparam logic [1:0] ERR_NONE          = 2'd0;
  localparam logic [1:0] ERR_TOO_LARGE     = 2'd1;
  localparam logic [1:0] ERR_NOT_CONNECTED = 2'd2;

  // Header field constants
  localparam logic [6:0] LEN_EXT16   = 7'd126;
  localparam logic [6:0] LEN_EXT64   = 7'd127;
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;
  localparam logic [3:0] BASE_HDR    = 4'd2;

  // One result item
  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic [3:0]  frame_opcode;
    logic        is_control;
    logic        frame_end;
    logic        message_end;
    logic [31:0] message_length;
    logic [1:0]  error_code;
  } res_t;

endpackage

`default_nettype wire

/* rtl/websocket_frame_deframer.sv */
// WebSocket frame deframer: header parse, length check, unmasking.
// Depends on wsfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  rx       | rx_valid / rx_stall  | in_byte
//  res      | res_valid / res_stall| out_byte .. error_code (8 fields)
//  cfg      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  One byte per cycle sustained unless a stalled result holds the flow; a result
//  reaches the ports through the input register, then the result register.
//  The header state update and the size check sit between those registers.
//  Reset (rst, synchronous) clears parse state and restores config defaults.
//  A stalled result holds; the input register still takes one more byte, and
//  bytes that make no result keep flowing while the result waits.
module websocket_frame_deframer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        rx_valid,
  output logic             rx_stall,
  input  wire logic [7:0]  in_byte,
  output logic             res_valid,
  input  wire logic        res_stall,
  output logic [7:0]       out_byte,
  output logic             byte_valid,
  output logic [3:0]       frame_opcode,
  output logic             is_control,
  output logic             frame_end,
  output logic             message_end,
  output logic [31:0]      message_length,
  output logic [1:0]       error_code,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  import wsfd_pkg::*;

  localparam logic [2:0] PH_HDR0 = 3'd0;
  localparam logic [2:0] PH_HDR1 = 3'd1;
  localparam logic [2:0] PH_EXT  = 3'd2;
  localparam logic [2:0] PH_KEY  = 3'd3;
  localparam logic [2:0] PH_DATA = 3'd4;
  localparam logic [2:0] PH_DROP = 3'd5;

  // Configuration
  logic        connected;
  logic [31:0] max_frame_bytes;

  // Input register
  logic        s1_valid;
  logic [7:0]  s1_byte;

  // Parse state
  logic [2:0]  phase, phase_next;
  logic [3:0]  field_byte_count, field_byte_count_next;
  logic        fin_flag, fin_flag_next;
  logic        masked_flag, masked_flag_next;
  logic [3:0]  current_opcode, current_opcode_next;
  logic [31:0] key_bytes, key_bytes_next;
  logic [63:0] payload_length, payload_length_next; // counts down through payload
  logic [1:0]  key_index, key_index_next;
  logic [3:0]  message_opcode, message_opcode_next;
  logic [31:0] message_bytes, message_bytes_next;
  logic [3:0]  header_len, header_len_next;

  // Result register
  res_t        res;
  res_t        res_next;
  logic        has_result;

  logic        out_free;
  logic        s1_fire;

  // Combinational helpers
  logic        lk_go;
  logic [63:0] lk_len;
  logic [3:0]  lk_hdr;
  logic        lk_over;
  logic [32:0] lk_sum;
  logic        sp_go;
  logic [63:0] sp_len;
  logic        ctl;
  logic        fend;
  logic        mend;
  logic [1:0]  key_pos;
  logic [7:0]  data_byte;
  logic [6:0]  len7;

  assign cfg_ready = 1'b1;
  assign out_free  = !res_valid || !res_stall;
  assign s1_fire   = s1_valid && (!has_result || out_free);
  assign rx_stall  = s1_valid && !s1_fire;

  assign len7    = s1_byte[6:0];
  assign key_pos = 2'(2'd0 - field_byte_count[1:0]);
  assign ctl     = current_opcode[3];

  // Size check: header plus payload reaching the limit
  assign lk_sum  = {1'b0, lk_len[31:0]} + 33'(lk_hdr);
  assign lk_over = (lk_len[63:32] != 32'd0) || (lk_sum >= {1'b0, max_frame_bytes});

  // Next state and result for the byte in the input register
  always_comb begin
    phase_next            = phase;
    field_byte_count_next = field_byte_count;
    fin_flag_next         = fin_flag;
    masked_flag_next      = masked_flag;
    current_opcode_next   = current_opcode;
    key_bytes_next        = key_bytes;
    payload_length_next   = payload_length;
    key_index_next        = key_index;
    message_opcode_next   = message_opcode;
    message_bytes_next    = message_bytes;
    header_len_next       = header_len;
    res_next              = '0;
    has_result            = 1'b0;
    lk_go                 = 1'b0;
    lk_len                = payload_length;
    lk_hdr                = header_len;
    sp_go                 = 1'b0;
    sp_len                = payload_length;
    fend                  = 1'b0;
    mend                  = 1'b0;
    data_byte             = s1_byte;

    if (!connected) begin
      // Reject every byte, keep state
      has_result          = 1'b1;
      res_next.error_code = ERR_NOT_CONNECTED;
    end else begin
      case (phase)
        PH_HDR0: begin
          fin_flag_next       = s1_byte[7];
          current_opcode_next = s1_byte[3:0];
          phase_next          = PH_HDR1;
        end
        PH_HDR1: begin
          masked_flag_next    = s1_byte[7];
          key_bytes_next      = '0;
          payload_length_next = '0;
          key_index_next      = '0;
          header_len_next     = s1_byte[7] ? (BASE_HDR + KEY_BYTES) : BASE_HDR;
          if (len7 inside {LEN_EXT16, LEN_EXT64}) begin
            field_byte_count_next = (len7 == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
            header_len_next       = header_len_next + field_byte_count_next;
            phase_next            = PH_EXT;
          end else begin
            payload_length_next = {57'd0, len7};
            lk_go  = 1'b1;
            lk_len = {57'd0, len7};
            lk_hdr = header_len_next;
          end
        end
        PH_EXT: begin
          payload_length_next = {payload_length[55:0], s1_byte};
          if (field_byte_count != 4'd0) begin
            field_byte_count_next = field_byte_count - 4'd1;
          end
          if (field_byte_count <= 4'd1) begin
            lk_go  = 1'b1;
            lk_len = payload_length_next;
          end
        end
        PH_KEY: begin
          key_bytes_next[8*key_pos +: 8] = s1_byte;
          if (field_byte_count != 4'd0) begin
            field_byte_count_next = field_byte_count - 4'd1;
          end
          if (field_byte_count <= 4'd1) begin
            sp_go = 1'b1;
          end
        end
        PH_DATA: begin
          if (masked_flag) begin
            data_byte = s1_byte ^ key_bytes[8*key_index +: 8];
          end
          key_index_next      = key_index + 2'd1;
          payload_length_next = payload_length - 64'd1;
          if (!ctl && message_bytes != 32'hFFFF_FFFF) begin
            message_bytes_next = message_bytes + 32'd1;
          end
          fend = (payload_length[63:1] == 63'd0);
          mend = fend && !ctl && fin_flag;
          has_result              = 1'b1;
          res_next.out_byte       = data_byte;
          res_next.byte_valid     = 1'b1;
          res_next.frame_opcode   = ctl ? current_opcode : message_opcode;
          res_next.is_control     = ctl;
          res_next.frame_end      = fend;
          res_next.message_end    = mend;
          res_next.message_length = message_bytes_next;
          if (mend) begin
            message_bytes_next = '0;
          end
          if (fend) begin
            phase_next = PH_HDR0;
          end
        end
        PH_DROP: begin
          // Drop silently until reset
        end
        default: begin
          phase_next = PH_HDR0;
        end
      endcase

      // Length known: size check, message opcode, then key or payload
      if (lk_go) begin
        if (lk_over) begin
          has_result          = 1'b1;
          res_next            = '0;
          res_next.error_code = ERR_TOO_LARGE;
          phase_next          = PH_DROP;
        end else begin
          if (!ctl && (message_bytes == 32'd0 || (!fin_flag && current_opcode != 4'd0))) begin
            message_opcode_next = current_opcode;
          end
          if (masked_flag_next) begin
            phase_next            = PH_KEY;
            field_byte_count_next = KEY_BYTES;
          end else begin
            sp_go  = 1'b1;
            sp_len = lk_len;
          end
        end
      end

      // Start payload; an empty frame ends here with one result
      if (sp_go) begin
        key_index_next = '0;
        if (sp_len == 64'd0) begin
          mend                    = !ctl && fin_flag;
          has_result              = 1'b1;
          res_next.frame_opcode   = ctl ? current_opcode : message_opcode_next;
          res_next.is_control     = ctl;
          res_next.frame_end      = 1'b1;
          res_next.message_end    = mend;
          res_next.message_length = message_bytes;
          if (mend) begin
            message_bytes_next = '0;
          end
          phase_next = PH_HDR0;
        end else begin
          phase_next = PH_DATA;
        end
      end
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      connected       <= 1'b0;
      max_frame_bytes <= MAX_FRAME_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CONNECTED: connected       <= cfg_data[0];
        CFG_MAX_FRAME: max_frame_bytes <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register: take a byte whenever the slot is free or draining
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rx_valid && !rx_stall) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_valid && !rx_stall) begin
      s1_byte <= in_byte;
    end
  end

  // Advance parse state once per processed byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HDR0;
      field_byte_count <= '0;
      fin_flag         <= 1'b0;
      masked_flag      <= 1'b0;
      current_opcode   <= '0;
      key_bytes        <= '0;
      payload_length   <= '0;
      key_index        <= '0;
      message_opcode   <= '0;
      message_bytes    <= '0;
      header_len       <= '0;
    end else if (s1_fire) begin
      phase            <= phase_next;
      field_byte_count <= field_byte_count_next;
      fin_flag         <= fin_flag_next;
      masked_flag      <= masked_flag_next;
      current_opcode   <= current_opcode_next;
      key_bytes        <= key_bytes_next;
      payload_length   <= payload_length_next;
      key_index        <= key_index_next;
      message_opcode   <= message_opcode_next;
      message_bytes    <= message_bytes_next;
      header_len       <= header_len_next;
    end
  end

  // Result register: load on a new result, clear when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_fire && has_result) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && has_result) begin
      res <= res_next;
    end
  end

  assign out_byte       = res.out_byte;
  assign byte_valid     = res.byte_valid;
  assign frame_opcode   = res.frame_opcode;
  assign is_control     = res.is_control;
  assign frame_end      = res.frame_end;
  assign message_end    = res.message_end;
  assign message_length = res.message_length;
  assign error_code     = res.error_code;

endmodule

`default_nettype wire

/* rtl/wsfd_checker.sv */
// Port-level checks for the WebSocket frame deframer, bound to the top level.
// Depends on wsfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wsfd_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        res_valid,
  input wire logic        res_stall,
  input wire logic [7:0]  out_byte,
  input wire logic        byte_valid,
  input wire logic [3:0]  frame_opcode,
  input wire logic        is_control,
  input wire logic        frame_end,
  input wire logic        message_end,
  input wire logic [31:0] message_length,
  input wire logic [1:0]  error_code
);
  import wsfd_pkg::*;

  // Hold a stalled result item
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(out_byte) && $stable(error_code)
      && $stable(message_length) && $stable(frame_end))
    else $error("stalled result changed");

  // Error items carry no byte, length or end flags
  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    res_valid && error_code != ERR_NONE |-> !byte_valid && !frame_end && !message_end
      && message_length == 32'd0 && out_byte == 8'd0)
    else $error("error item carries payload fields");

  // Message end only closes a data frame
  a_mend: assert property (@(posedge clk) disable iff (rst)
    res_valid && message_end |-> frame_end && !is_control)
    else $error("message end outside a closing data frame");

  // Control flag follows the opcode on regular items
  a_ctl: assert property (@(posedge clk) disable iff (rst)
    res_valid && error_code == ERR_NONE |-> is_control == frame_opcode[3])
    else $error("control flag disagrees with opcode");

  // No undefined error code
  a_code: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> error_code == ERR_NONE || error_code == ERR_TOO_LARGE
      || error_code == ERR_NOT_CONNECTED)
    else $error("undefined error code");

endmodule

bind websocket_frame_deframer wsfd_checker u_wsfd_checker (
  .clk            (clk),
  .rst            (rst),
  .res_valid      (res_valid),
  .res_stall      (res_stall),
  .out_byte       (out_byte),
  .byte_valid     (byte_valid),
  .frame_opcode   (frame_opcode),
  .is_control     (is_control),
  .frame_end      (frame_end),
  .message_end    (message_end),
  .message_length (message_length),
  .error_code     (error_code)
);

`default_nettype wire
